### rtl/core/mld_pkg.sv
// mld_pkg: shared types and constants of the mip level downsampler
// no dependencies
`default_nettype none

package mld_pkg;

  // widths of the clamped geometry values
  localparam int DIM_W   = 15;
  localparam int DEPTH_W = 13;

  // raw register widths
  localparam int MODE_W  = 1;
  localparam int WIDTH_W = 13;
  localparam int HEIGHT_W = 13;
  localparam int LAYER_W = 9;
  localparam int COUNT_W = 3;

  // line store entry: four 10-bit fields
  localparam int FIELD_W = 10;
  localparam int ENTRY_W = 4 * FIELD_W;

  // apb address width and register indexes
  localparam int PADDR_W = 5;
  localparam int REG_W   = 3;
  localparam logic [REG_W-1:0] REG_DOWN_MODE       = 3'd0;
  localparam logic [REG_W-1:0] REG_LEVEL_WIDTH     = 3'd1;
  localparam logic [REG_W-1:0] REG_LEVEL_HEIGHT    = 3'd2;
  localparam logic [REG_W-1:0] REG_LEVEL_DEPTH     = 3'd3;
  localparam logic [REG_W-1:0] REG_COMPONENT_COUNT = 3'd4;

  // register reset values
  localparam logic [MODE_W-1:0]   RST_DOWN_MODE       = 1'b1;
  localparam logic [WIDTH_W-1:0]  RST_LEVEL_WIDTH     = 13'd1;
  localparam logic [HEIGHT_W-1:0] RST_LEVEL_HEIGHT    = 13'd1;
  localparam logic [LAYER_W-1:0]  RST_LEVEL_DEPTH     = 9'd1;
  localparam logic [COUNT_W-1:0]  RST_COMPONENT_COUNT = 3'd4;

  // configuration seen by the datapath
  typedef struct packed {
    logic               box;
    logic [COUNT_W-1:0] ccount;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [DEPTH_W-1:0] depth;
    logic               restart;
  } cfg_t;

  // per-pixel decision from the raster scan
  typedef struct packed {
    logic [3:0][8:0] near;
    logic            odd_row;
    logic            eol;
    logic            wr;
    logic            rd;
    logic            emit;
  } step_t;

endpackage

`default_nettype wire

### rtl/core/mld_ifs.sv
// mld_in_if, mld_out_if: valid/ready pixel channels of the downsampler
// no dependencies
`default_nettype none

interface mld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;

  modport source(output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink(input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface mld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       end_of_level;

  modport source(output valid, out_red, out_green, out_blue, out_alpha, end_of_level,
                 input ready);
  modport sink(input valid, out_red, out_green, out_blue, out_alpha, end_of_level,
               output ready);
endinterface

`default_nettype wire

### rtl/core/mld_regs.sv
// mld_regs: apb configuration registers and geometry clamping
// depends on mld_pkg
`default_nettype none

module mld_regs #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_DEPTH  = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [mld_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output      logic [31:0]               prdata,
  output      logic                      pready,
  output      mld_pkg::cfg_t             cfg
);
  import mld_pkg::*;

  localparam logic [DIM_W-1:0]   MAXW_C = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]   MAXH_C = DIM_W'(MAX_HEIGHT);
  localparam logic [DEPTH_W-1:0] MAXD_C = DEPTH_W'(MAX_DEPTH);

  logic [MODE_W-1:0]   down_mode;
  logic [WIDTH_W-1:0]  level_width;
  logic [HEIGHT_W-1:0] level_height;
  logic [LAYER_W-1:0]  level_depth;
  logic [COUNT_W-1:0]  component_count;
  logic [REG_W-1:0]    idx;
  logic                wr_en;
  logic [DIM_W-1:0]    w_ext;
  logic [DIM_W-1:0]    h_ext;
  logic [DEPTH_W-1:0]  d_ext;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      down_mode       <= RST_DOWN_MODE;
      level_width     <= RST_LEVEL_WIDTH;
      level_height    <= RST_LEVEL_HEIGHT;
      level_depth     <= RST_LEVEL_DEPTH;
      component_count <= RST_COMPONENT_COUNT;
    end else if (wr_en) begin
      case (idx)
        REG_DOWN_MODE:       down_mode       <= pwdata[MODE_W-1:0];
        REG_LEVEL_WIDTH:     level_width     <= pwdata[WIDTH_W-1:0];
        REG_LEVEL_HEIGHT:    level_height    <= pwdata[HEIGHT_W-1:0];
        REG_LEVEL_DEPTH:     level_depth     <= pwdata[LAYER_W-1:0];
        REG_COMPONENT_COUNT: component_count <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_DOWN_MODE:       prdata = 32'(down_mode);
      REG_LEVEL_WIDTH:     prdata = 32'(level_width);
      REG_LEVEL_HEIGHT:    prdata = 32'(level_height);
      REG_LEVEL_DEPTH:     prdata = 32'(level_depth);
      REG_COMPONENT_COUNT: prdata = 32'(component_count);
      default:             prdata = 32'd0;
    endcase
  end

  // zero acts as one, oversize saturates at the build limit
  assign w_ext = DIM_W'(level_width);
  assign h_ext = DIM_W'(level_height);
  assign d_ext = DEPTH_W'(level_depth);

  always_comb begin
    cfg.box     = down_mode[0];
    cfg.ccount  = component_count;
    cfg.restart = wr_en && (idx inside {[REG_DOWN_MODE:REG_COMPONENT_COUNT]});

    if (w_ext == '0)          cfg.width = DIM_W'(1);
    else if (w_ext > MAXW_C)  cfg.width = MAXW_C;
    else                      cfg.width = w_ext;

    if (h_ext == '0)          cfg.height = DIM_W'(1);
    else if (h_ext > MAXH_C)  cfg.height = MAXH_C;
    else                      cfg.height = h_ext;

    if (d_ext == '0)          cfg.depth = DEPTH_W'(1);
    else if (d_ext > MAXD_C)  cfg.depth = MAXD_C;
    else                      cfg.depth = d_ext;
  end

endmodule

`default_nettype wire

### rtl/core/mld_scan.sv
// mld_scan: raster position counters, left pixel hold and per-pixel decisions
// depends on mld_pkg
`default_nettype none

module mld_scan #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_DEPTH  = 256,
  parameter int AW         = 11
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mld_pkg::cfg_t   cfg,
  input  wire logic            accept,
  input  wire logic [3:0][7:0] cur,
  output      mld_pkg::step_t  step,
  output      logic [AW-1:0]   addr
);
  import mld_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int ZW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  logic [ZW-1:0]    layer;
  logic [3:0][7:0]  hold;
  logic [3:0][7:0]  left;
  logic             odd_col;
  logic             last_col;
  logic             last_row;
  logic             last_layer;
  logic             pair_done;

  // position flags
  assign odd_col    = col[0];
  assign last_col   = (DIM_W'(col) + DIM_W'(1)) >= cfg.width;
  assign last_row   = (DIM_W'(row) + DIM_W'(1)) >= cfg.height;
  assign last_layer = (DEPTH_W'(layer) + DEPTH_W'(1)) >= cfg.depth;
  assign pair_done  = odd_col || last_col;
  assign left       = odd_col ? hold : cur;
  assign addr       = AW'(col >> 1);

  // near value: pair sum in box mode, top-left pixel in point mode
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      step.near[c] = cfg.box ? ({1'b0, left[c]} + {1'b0, cur[c]}) : {1'b0, left[c]};
    end
    step.odd_row = row[0];
    step.eol     = last_col && last_row && last_layer;
    step.wr      = accept && pair_done && !row[0];
    step.rd      = accept && pair_done && row[0];
    step.emit    = accept && pair_done && (row[0] || last_row);
  end

  // counters and left hold
  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col   <= '0;
      row   <= '0;
      layer <= '0;
      hold  <= '0;
    end else if (accept) begin
      if (!odd_col) begin
        hold <= cur;
      end
      if (last_col) begin
        col <= '0;
        if (last_row) begin
          row   <= '0;
          layer <= last_layer ? '0 : layer + 1'b1;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/mld_line_store.sv
// mld_line_store: one-port line store of even-row pair sums, registered read
// depends on mld_pkg
`default_nettype none

module mld_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic                        clk,
  input  wire logic                        wr,
  input  wire logic                        rd,
  input  wire logic [AW-1:0]               addr,
  input  wire logic [mld_pkg::ENTRY_W-1:0] wdata,
  output      logic [mld_pkg::ENTRY_W-1:0] rdata
);
  import mld_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  // write on even rows, read on odd rows
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[addr] <= wdata;
    end
    if (rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/mip_level_downsampler.sv
// mip_level_downsampler: 2x2 box or point mipmap downsampler, top level
// depends on mld_pkg, mld_ifs, mld_regs, mld_scan, mld_line_store
//
// usage: source pixels arrive on pix_in in raster order (x, then y, then
// layer); one pixel of the next smaller level leaves on pix_out for each
// 2x2 block, on the request that completes the block (odd column or last
// column of an odd row or of the last row). end_of_level marks the final
// output pixel of the level. geometry, mode and component count are written
// over the apb port while the block is idle; any such write restarts the
// scan at the first pixel of the level.
// path: the request that completes a block goes through the line store read
// stage, then the output register, before its result is valid.
// throughput: one request per cycle unless the output stalls; each pixel makes
// at most one access to the single-port line store, which sets that figure.
// reset: counters, left hold and pipeline valids clear; registers take their
// reset values. the line store is not cleared: every entry is written on an
// even row before an odd row reads it.
// stall: a held result stays in the output register; one more result waits
// in the read stage, and input keeps flowing until that stage is full.
`default_nettype none

module mip_level_downsampler #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_DEPTH  = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mld_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready,
  mld_in_if.sink                           pix_in,
  mld_out_if.source                        pix_out
);
  import mld_pkg::*;

  localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  cfg_t               cfg;
  step_t              step;
  logic [AW-1:0]      addr;
  logic [3:0][7:0]    cur;
  logic               accept;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;

  logic               s1_valid;
  logic [3:0][8:0]    s1_near;
  logic               s1_odd_row;
  logic               s1_eol;
  logic [3:0][7:0]    res;

  logic               out_valid;
  logic [3:0][7:0]    out_pix;
  logic               out_eol;
  logic               out_free;
  logic               s1_fire;

  mld_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // handshake
  assign out_free     = !out_valid || pix_out.ready;
  assign s1_fire      = s1_valid && out_free;
  assign pix_in.ready = !s1_valid || out_free;
  assign accept       = pix_in.valid && pix_in.ready;
  assign cur          = {pix_in.in_alpha, pix_in.in_blue, pix_in.in_green, pix_in.in_red};

  mld_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_DEPTH (MAX_DEPTH),
    .AW        (AW)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .accept(accept),
    .cur   (cur),
    .step  (step),
    .addr  (addr)
  );

  // pack four 10-bit fields for the line store
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      wdata[c*FIELD_W +: FIELD_W] = {1'b0, step.near[c]};
    end
  end

  mld_line_store #(
    .DEPTH(STORE_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .wr   (step.wr),
    .rd   (step.rd),
    .addr (addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  // read stage: holds the request while the line store answers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= step.emit;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step.emit) begin
      s1_near    <= step.near;
      s1_odd_row <= step.odd_row;
      s1_eol     <= step.eol;
    end
  end

  // combine with the stored top pair and mask unused components
  always_comb begin
    logic [9:0]  top;
    logic [10:0] sum;
    for (int c = 0; c < 4; c++) begin
      top = rdata[c*FIELD_W +: FIELD_W];
      sum = 11'(top) + 11'(s1_near[c]);
      if (COUNT_W'(c) >= cfg.ccount) begin
        res[c] = 8'd0;
      end else if (s1_odd_row) begin
        res[c] = cfg.box ? sum[9:2] : top[7:0];
      end else begin
        res[c] = cfg.box ? s1_near[c][8:1] : s1_near[c][7:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pix <= res;
      out_eol <= s1_eol;
    end
  end

  assign pix_out.valid        = out_valid;
  assign pix_out.out_red      = out_pix[0];
  assign pix_out.out_green    = out_pix[1];
  assign pix_out.out_blue     = out_pix[2];
  assign pix_out.out_alpha    = out_pix[3];
  assign pix_out.end_of_level = out_eol;

endmodule

`default_nettype wire

### tb/mld_checker.sv
// mld_checker: watches the apb port and both pixel channels of the downsampler,
// predicts each output pixel and compares it field by field
// depends on mld_pkg and mld_ifs
module mld_checker #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_DEPTH  = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [mld_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  mld_in_if                           pix_in,
  mld_out_if                          pix_out,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mld_pkg::*;

  localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       end_of_level;
  } level_pixel_t;

  // mirrored registers
  logic                box_mode;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [LAYER_W-1:0]  depth_reg;
  logic [COUNT_W-1:0]  count_reg;

  // scan state of the predictor
  logic [ENTRY_W-1:0]  pair_store [STORE_DEPTH];
  logic [31:0]         left_hold;
  int unsigned         col, row, layer;

  // output pixels owed, oldest first
  level_pixel_t        expected_pixels [$];

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void restart_scan();
    col = 0;
    row = 0;
    layer = 0;
    left_hold = '0;
  endfunction

  function automatic void write_register(input logic [REG_W-1:0] index,
                                         input logic [31:0] value);
    case (index)
      REG_DOWN_MODE:       box_mode = value[0];
      REG_LEVEL_WIDTH:     width_reg = value[WIDTH_W-1:0];
      REG_LEVEL_HEIGHT:    height_reg = value[HEIGHT_W-1:0];
      REG_LEVEL_DEPTH:     depth_reg = value[LAYER_W-1:0];
      REG_COMPONENT_COUNT: count_reg = value[COUNT_W-1:0];
      default:             return;
    endcase
    restart_scan();
  endfunction

  // one source pixel through the 2x2 filter; queues the output pixel it completes
  function automatic void downsample_pixel(input logic [31:0] cur);
    int unsigned        w, h, d, idx;
    logic               odd_col, last_col, last_row, last_layer, emit;
    logic [31:0]        left;
    logic [ENTRY_W-1:0] entry;
    logic [FIELD_W-1:0] v;
    logic [10:0]        sum;
    logic [7:0]         comp [4];
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    d = clamp_dim(depth_reg, MAX_DEPTH);
    odd_col = col[0];
    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);
    last_layer = (layer + 1 >= d);
    emit = 1'b0;
    if (odd_col || last_col) begin
      // a missing right neighbour is the pixel itself
      left = odd_col ? left_hold : cur;
      idx = (col >> 1) % STORE_DEPTH;
      if (!row[0]) begin
        // even row: keep the pair sum, emit at once on a last even row
        for (int c = 0; c < 4; c++) begin
          v = box_mode ? 10'(left[8*c +: 8]) + 10'(cur[8*c +: 8]) : 10'(left[8*c +: 8]);
          entry[FIELD_W*c +: FIELD_W] = v;
          sum = box_mode ? (11'(v) << 1) >> 2 : 11'(v);
          comp[c] = sum[7:0];
        end
        pair_store[idx] = entry;
        emit = last_row;
      end else begin
        // odd row: complete the block from the stored top pair
        entry = pair_store[idx];
        for (int c = 0; c < 4; c++) begin
          v = entry[FIELD_W*c +: FIELD_W];
          sum = box_mode ? (11'(v) + 11'(left[8*c +: 8]) + 11'(cur[8*c +: 8])) >> 2
                         : 11'(v);
          comp[c] = sum[7:0];
        end
        emit = 1'b1;
      end
      if (emit) begin
        // unused components read as zero
        for (int c = 0; c < 4; c++) begin
          if (c >= count_reg) comp[c] = '0;
        end
        expected_pixels.push_back('{comp[0], comp[1], comp[2], comp[3],
                                    last_col && last_row && last_layer});
      end
    end
    if (!odd_col) left_hold = cur;
    // raster counters
    if (last_col) begin
      col = 0;
      if (last_row) begin
        row = 0;
        layer = last_layer ? 0 : layer + 1;
      end else begin
        row = row + 1;
      end
    end else begin
      col = col + 1;
    end
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // monitor: register writes, results, then new requests
  always @(posedge clk) begin : monitor
    level_pixel_t want, got;
    if (rst) begin
      box_mode = RST_DOWN_MODE;
      width_reg = RST_LEVEL_WIDTH;
      height_reg = RST_LEVEL_HEIGHT;
      depth_reg = RST_LEVEL_DEPTH;
      count_reg = RST_COMPONENT_COUNT;
      for (int i = 0; i < STORE_DEPTH; i++) pair_store[i] = '0;
      restart_scan();
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        write_register(paddr[PADDR_W-1:2], pwdata);
      end
      if (pix_out.valid && pix_out.ready) begin
        got = '{pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                pix_out.out_alpha, pix_out.end_of_level};
        if (expected_pixels.size() == 0) begin
          $display("%0t: output pixel expected none, got %h", $time, got);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          compare_field("out_red", want.red, got.red);
          compare_field("out_green", want.green, got.green);
          compare_field("out_blue", want.blue, got.blue);
          compare_field("out_alpha", want.alpha, got.alpha);
          compare_field("end_of_level", want.end_of_level, got.end_of_level);
        end
      end
      if (pix_in.valid && pix_in.ready) begin
        downsample_pixel({pix_in.in_alpha, pix_in.in_blue, pix_in.in_green, pix_in.in_red});
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

### tb/tb_mip_level_downsampler.sv
// tb_mip_level_downsampler: stimulus and verdict for the mip level downsampler
// depends on mld_pkg, mld_ifs, mip_level_downsampler and mld_checker
module tb_mip_level_downsampler;
  timeunit 1ns;
  timeprecision 1ps;
  import mld_pkg::*;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_DEPTH    = 256;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 120;
  localparam int SHORT_ITEMS  = 16;

  // an index past the last register
  localparam logic [REG_W-1:0] REG_UNUSED = 3'd7;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               steady;
  int                 fail_count;
  int                 pending;

  mld_in_if  pix_in_ch();
  mld_out_if pix_out_ch();

  mip_level_downsampler #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_DEPTH(MAX_DEPTH)
  ) i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pix_in(pix_in_ch), .pix_out(pix_out_ch)
  );

  mld_checker #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_DEPTH(MAX_DEPTH)
  ) i_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .pix_in(pix_in_ch), .pix_out(pix_out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always #6 clk = ~clk;

  // output side stalls at random except in steady stretches
  always @(posedge clk) begin
    pix_out_ch.ready <= steady || ($urandom_range(99) >= 12);
  end

  // run limit
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] rand_pixel();
    return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
  endfunction

  // sometimes sets bits above the register field
  function automatic logic [31:0] with_noise(input int unsigned v, input int bits);
    if ($urandom_range(3) == 0) return v | ($urandom << bits);
    return v;
  endfunction

  function automatic int unsigned span(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  // apb write: setup then access
  task automatic write_reg(input logic [REG_W-1:0] index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] mode, input logic [31:0] w,
                           input logic [31:0] h, input logic [31:0] d,
                           input logic [31:0] count);
    write_reg(REG_DOWN_MODE, mode);
    write_reg(REG_LEVEL_WIDTH, w);
    write_reg(REG_LEVEL_HEIGHT, h);
    write_reg(REG_LEVEL_DEPTH, d);
    write_reg(REG_COMPONENT_COUNT, count);
  endtask

  // one pixel request, {alpha, blue, green, red}
  task automatic push_pixel(input logic [31:0] p);
    while (!steady && $urandom_range(99) < 12) begin
      pix_in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in_ch.valid <= 1'b1;
    pix_in_ch.in_red <= p[7:0];
    pix_in_ch.in_green <= p[15:8];
    pix_in_ch.in_blue <= p[23:16];
    pix_in_ch.in_alpha <= p[31:24];
    do @(posedge clk); while (!pix_in_ch.ready);
  endtask

  task automatic push_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_pixel(rand_pixel());
  endtask

  // idle the input and let every owed result leave
  task automatic wait_drained();
    pix_in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned sent, mode, w, h, d, count, full, items;
    rst <= 1'b1;
    steady <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pix_in_ch.valid <= 1'b0;
    pix_in_ch.in_red <= '0;
    pix_in_ch.in_green <= '0;
    pix_in_ch.in_blue <= '0;
    pix_in_ch.in_alpha <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: every pixel is a whole level
    push_pixel(32'hFFFF_FFFF);
    push_pixel(32'h0000_0000);
    push_pixel(32'hF00F_AA55);
    wait_drained();

    // box average rounds down
    configure(1, 2, 2, 1, 4);
    push_pixel({8'd2, 8'd1, 8'd0, 8'd255});
    push_pixel({8'd1, 8'd1, 8'd0, 8'd255});
    push_pixel({8'd1, 8'd2, 8'd0, 8'd255});
    push_pixel({8'd1, 8'd1, 8'd0, 8'd254});
    wait_drained();

    // point sample on odd edges, two components
    configure(0, 3, 3, 1, 2);
    push_random(9);
    wait_drained();

    // zero geometry acts as one, zero components
    configure(1, 0, 0, 0, 0);
    push_random(1);
    wait_drained();

    // a write past the last register keeps the scan, a real write restarts it
    configure(1, 2, 1, 1, 7);
    push_random(1);
    wait_drained();
    write_reg(REG_UNUSED, $urandom);
    push_random(2);
    wait_drained();
    write_reg(REG_COMPONENT_COUNT, 3);
    push_random(2);
    wait_drained();

    // oversize depth saturates at the maximum and wraps after it
    steady <= 1'b1;
    configure(1, 1, 1, 511, 5);
    push_random(MAX_DEPTH + 1);
    wait_drained();
    // oversize width and height: the start of a level, no early end
    configure(1, 8191, 1, 1, 4);
    push_random(SHORT_ITEMS);
    wait_drained();
    steady <= 1'b0;
    configure(0, 1, 8191, 1, 3);
    push_random(SHORT_ITEMS);
    wait_drained();

    // random levels: mostly whole ones, some cut short
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(1);
      w = $urandom_range(0, 9);
      h = $urandom_range(0, 7);
      d = $urandom_range(0, 3);
      count = $urandom_range(0, 7);
      configure(with_noise(mode, MODE_W), with_noise(w, WIDTH_W),
                with_noise(h, HEIGHT_W), with_noise(d, LAYER_W),
                with_noise(count, COUNT_W));
      full = span(w) * span(h) * span(d);
      if ($urandom_range(99) < 85) items = full * $urandom_range(1, 2);
      else items = $urandom_range(1, full);
      if (items > RANDOM_ITEMS - sent) items = RANDOM_ITEMS - sent;
      push_random(items);
      sent += items;
      wait_drained();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### mip_level_downsampler.f
rtl/core/mld_pkg.sv
rtl/core/mld_ifs.sv
rtl/core/mld_regs.sv
rtl/core/mld_scan.sv
rtl/core/mld_line_store.sv
rtl/core/mip_level_downsampler.sv
tb/mld_checker.sv
tb/tb_mip_level_downsampler.sv
